[hdl/pic_pkg.sv]
// package: shared types and constants for the polymorphic inline cache
`default_nettype none
package pic_pkg;

   localparam logic [1:0] MODE_UNINIT = 2'd0;
   localparam logic [1:0] MODE_MONO   = 2'd1;
   localparam logic [1:0] MODE_POLY   = 2'd2;
   localparam logic [1:0] MODE_MEGA   = 2'd3;

   localparam logic OP_ACCESS     = 1'b0;
   localparam logic OP_INVALIDATE = 1'b1;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 88;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage
`default_nettype wire

[hdl/pic_ctrl.sv]
// controller: handshake sequencing for the polymorphic inline cache
`default_nettype none
module pic_ctrl
   import pic_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output dp_cmd_type      cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

[hdl/pic_datapath.sv]
// datapath: tag table, probe, fill logic, counters and result register
`default_nettype none
module pic_datapath
   import pic_pkg::*;
#(
   parameter int MAX_ENTRIES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dp_cmd_type            cmd,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  csr_write,
   input  wire logic                  csr_value,
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic          load_site_ff;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   tag_ff [MAX_ENTRIES];
   logic [15:0]   slot_ff [MAX_ENTRIES];
   logic [31:0]   hit_cnt_ff, hit_cnt_in;
   logic [31:0]   miss_cnt_ff, miss_cnt_in;

   logic          op_ff;
   logic [31:0]   shape_ff;
   logic          present_ff;
   logic          fvalid_ff;
   logic [31:0]   fshape_ff;
   logic [15:0]   fslot_ff;

   logic          res_hit_ff, res_hit_in;
   logic          res_svalid_ff, res_svalid_in;
   logic [15:0]   res_slot_ff, res_slot_in;
   logic [1:0]    res_mode_ff;
   logic [2:0]    res_used_ff;
   logic [31:0]   res_hits_ff;
   logic [31:0]   res_misses_ff;

   logic [MAX_ENTRIES-1:0] probe_match;
   logic [MAX_ENTRIES-1:0] fill_match;
   logic                   probe_hit;
   logic [15:0]            probe_slot;
   logic                   hit;
   logic                   do_fill;
   logic [31:0]            ins_tag;
   logic                   wr_en;
   logic [CW-1:0]          wr_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_site_ff <= 1'b1;
      end else if (csr_write) begin
         load_site_ff <= csr_value;
      end
   end

   // input item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_tuser;
         shape_ff   <= req_tdata[31:0];
         present_ff <= req_tdata[32];
         fvalid_ff  <= req_tdata[33];
         fshape_ff  <= req_tdata[65:34];
         fslot_ff   <= req_tdata[81:66];
      end
   end

   assign ins_tag = load_site_ff ? shape_ff : fshape_ff;

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         probe_match[i] = (cnt_ff > CW'(i)) && (tag_ff[i] == shape_ff);
         fill_match[i]  = (cnt_ff > CW'(i)) && (tag_ff[i] == ins_tag);
      end
   end

   // lowest matching entry wins
   always_comb begin
      probe_hit  = 1'b0;
      probe_slot = '0;
      unique case (mode_ff)
         MODE_MONO: begin
            probe_hit  = (tag_ff[0] == shape_ff);
            probe_slot = slot_ff[0];
         end
         MODE_POLY: begin
            probe_hit = |probe_match;
            for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
               if (probe_match[i]) begin
                  probe_slot = slot_ff[i];
               end
            end
         end
         default: begin
            probe_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      hit         = (op_ff == OP_ACCESS) && present_ff && probe_hit;
      do_fill     = (op_ff == OP_ACCESS) && !hit &&
                    (load_site_ff ? (present_ff && fvalid_ff) : fvalid_ff);
      mode_in     = mode_ff;
      cnt_in      = cnt_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      wr_en       = 1'b0;
      wr_idx      = '0;
      res_hit_in    = 1'b0;
      res_svalid_in = 1'b0;
      res_slot_in   = '0;
      if (op_ff == OP_INVALIDATE) begin
         mode_in = MODE_UNINIT;
         cnt_in  = '0;
      end else if (hit) begin
         res_hit_in    = 1'b1;
         res_svalid_in = 1'b1;
         res_slot_in   = probe_slot;
         if (hit_cnt_ff != 32'hFFFF_FFFF) begin
            hit_cnt_in = hit_cnt_ff + 32'd1;
         end
      end else begin
         if (miss_cnt_ff != 32'hFFFF_FFFF) begin
            miss_cnt_in = miss_cnt_ff + 32'd1;
         end
         if (do_fill) begin
            res_svalid_in = 1'b1;
            res_slot_in   = fslot_ff;
            unique case (mode_ff)
               MODE_UNINIT: begin
                  mode_in = MODE_MONO;
                  wr_en   = 1'b1;
                  wr_idx  = CW'(0);
                  cnt_in  = CW'(1);
               end
               MODE_MONO: begin
                  if (ins_tag != tag_ff[0]) begin
                     mode_in = MODE_POLY;
                     wr_en   = 1'b1;
                     wr_idx  = CW'(1);
                     cnt_in  = CW'(2);
                  end
               end
               MODE_POLY: begin
                  if (!(|fill_match)) begin
                     if (cnt_ff < CW'(MAX_ENTRIES)) begin
                        wr_en  = 1'b1;
                        wr_idx = cnt_ff;
                        cnt_in = cnt_ff + CW'(1);
                     end else begin
                        mode_in = MODE_MEGA;
                     end
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_UNINIT;
         cnt_ff      <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (cmd.execute) begin
         mode_ff     <= mode_in;
         cnt_ff      <= cnt_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (cmd.execute && wr_en && (wr_idx == CW'(i))) begin
            tag_ff[i]  <= ins_tag;
            slot_ff[i] <= fslot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         res_hit_ff    <= res_hit_in;
         res_svalid_ff <= res_svalid_in;
         res_slot_ff   <= res_slot_in;
         res_mode_ff   <= mode_in;
         res_used_ff   <= 3'(cnt_in);
         res_hits_ff   <= hit_cnt_in;
         res_misses_ff <= miss_cnt_in;
      end
   end

   assign rsp_tdata = {1'b0, res_misses_ff, res_hits_ff, res_used_ff, res_mode_ff,
                       res_slot_ff, res_svalid_ff, res_hit_ff};

endmodule
`default_nettype wire

[hdl/polymorphic_inline_cache.sv]
// Polymorphic inline cache for one property access site.
// req channel: one item per access or invalidate; tuser selects the kind
// (0 access, 1 invalidate), tdata carries shape, fill request and fill slot.
// rsp channel: one item per request with hit, slot, cache mode, entry count
// and the saturating hit and miss totals after the step.
// csr channel: writes the load_site bit (1 load site, 0 store site); always
// ready. The user must write it only while no request is in flight; the
// block does not enforce this. Each item is first captured into the input
// registers; then the tag compare and table update run and the result
// register loads, and the result is valid once it has loaded. The next
// request is taken in the same cycle the result is taken, so no new request
// is taken while one is being executed.
// A stalled result stays in its register and holds off further requests
// until it is taken.
// Reset empties the table, clears both totals and sets load_site to 1.
`default_nettype none
module polymorphic_inline_cache
   import pic_pkg::*;
#(
   parameter int MAX_ENTRIES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // shape_id[31:0], shape_present[32], fill_valid[33], fill_shape_id[65:34],
   // fill_slot[81:66], zero fill above
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // mode[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // hit[0], slot_valid[1], slot[17:2], cache_mode[19:18], entries_used[22:20],
   // hit_total[54:23], miss_total[86:55], zero fill above
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_data
);

   dp_cmd_type cmd;

   assign csr_ready = 1'b1;

   pic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pic_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

[bench/testbench.sv]
// testbench for the polymorphic inline cache: directed and random items checked by a predictor
module testbench;
   import pic_pkg::*;

   localparam int MAX_ENTRIES = 4;
   localparam int QUIET_LIMIT = 600;
   localparam int PHASE_ITEMS = 350;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 60;

   typedef struct packed {
      logic [5:0]  pad;
      logic [15:0] fill_slot;
      logic [31:0] fill_shape_id;
      logic        fill_valid;
      logic        shape_present;
      logic [31:0] shape_id;
   } access_req_type;

   typedef struct packed {
      logic        pad;
      logic [31:0] miss_total;
      logic [31:0] hit_total;
      logic [2:0]  entries_used;
      logic [1:0]  cache_mode;
      logic [15:0] slot;
      logic        slot_valid;
      logic        hit;
   } access_result_type;

   typedef struct packed {
      logic              is_csr;
      logic              site;
      logic              op;
      access_req_type    rq;
      logic              has_known;
      access_result_type known;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // shape_id, shape_present, fill_valid,
                                            // fill_shape_id, fill_slot, zero fill
   logic                  req_tuser = OP_ACCESS;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // hit, slot_valid, slot, cache_mode,
                                            // entries_used, hit_total, miss_total, zero fill
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_data = 1'b0;

   logic                  offer_typed = 1'b0;
   access_result_type     offer_known = '0;

   // predicted cache state
   logic                  site_is_load;
   logic [1:0]            pred_mode;
   logic [31:0]           pred_tag [MAX_ENTRIES];
   logic [15:0]           pred_slot [MAX_ENTRIES];
   int                    pred_used;
   logic [31:0]           pred_hits;
   logic [31:0]           pred_misses;

   access_result_type     pending_results[$];
   plan_row_type          plan[$];
   int                    mismatches = 0;
   int                    quiet_cycles = 0;
   int                    offers_made = 0;
   bit                    sender_eager = 0;
   logic [31:0]           shape_pool [6];

   polymorphic_inline_cache #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] sat_bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic void clear_table();
      pred_mode = MODE_UNINIT;
      pred_used = 0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         pred_tag[i]  = '0;
         pred_slot[i] = '0;
      end
   endfunction

   function automatic void add_row(input plan_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   // index of the matching entry, or -1
   function automatic int lookup(input logic [31:0] tag);
      if (pred_mode == MODE_MONO) begin
         return (pred_tag[0] == tag) ? 0 : -1;
      end
      if (pred_mode == MODE_POLY) begin
         for (int i = 0; i < pred_used; i++) begin
            if (pred_tag[i] == tag) begin
               return i;
            end
         end
      end
      return -1;
   endfunction

   function automatic void record_shape(input logic [31:0] tag, input logic [15:0] slot);
      case (pred_mode)
         MODE_UNINIT: begin
            pred_mode    = MODE_MONO;
            pred_tag[0]  = tag;
            pred_slot[0] = slot;
            pred_used    = 1;
         end
         MODE_MONO: begin
            if (tag != pred_tag[0]) begin
               pred_mode    = MODE_POLY;
               pred_tag[1]  = tag;
               pred_slot[1] = slot;
               pred_used    = 2;
            end
         end
         MODE_POLY: begin
            if (lookup(tag) < 0) begin
               if (pred_used < MAX_ENTRIES) begin
                  pred_tag[pred_used]  = tag;
                  pred_slot[pred_used] = slot;
                  pred_used++;
               end else begin
                  pred_mode = MODE_MEGA;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic access_result_type cache_step(input logic op, input access_req_type rq);
      access_result_type r;
      int                idx;
      r = '0;
      if (op == OP_INVALIDATE) begin
         clear_table();
      end else begin
         idx = rq.shape_present ? lookup(rq.shape_id) : -1;
         if (idx >= 0) begin
            r.hit        = 1'b1;
            r.slot_valid = 1'b1;
            r.slot       = pred_slot[idx];
            pred_hits    = sat_bump(pred_hits);
         end else begin
            pred_misses = sat_bump(pred_misses);
            // store sites fill even without a shape
            if (rq.fill_valid && (rq.shape_present || !site_is_load)) begin
               record_shape(site_is_load ? rq.shape_id : rq.fill_shape_id, rq.fill_slot);
               r.slot_valid = 1'b1;
               r.slot       = rq.fill_slot;
            end
         end
      end
      r.cache_mode   = pred_mode;
      r.entries_used = 3'(pred_used);
      r.hit_total    = pred_hits;
      r.miss_total   = pred_misses;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      access_result_type want;
      access_result_type seen;
      if (reset) begin
         site_is_load = 1'b1;
         clear_table();
         pred_hits   = '0;
         pred_misses = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            site_is_load = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = access_result_type'(rsp_tdata);
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none got %0h", $time, seen);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("hit", want.hit, seen.hit);
               check_field("slot_valid", want.slot_valid, seen.slot_valid);
               check_field("slot", want.slot, seen.slot);
               check_field("cache_mode", want.cache_mode, seen.cache_mode);
               check_field("entries_used", want.entries_used, seen.entries_used);
               check_field("hit_total", want.hit_total, seen.hit_total);
               check_field("miss_total", want.miss_total, seen.miss_total);
            end
         end
         if (req_tvalid && req_tready) begin
            want = cache_step(req_tuser, access_req_type'(req_tdata));
            if (offer_typed) begin
               want = offer_known;
            end
            pending_results.insert(pending_results.size(), want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, bursts without stalls, and one long hold
   initial begin : result_sink
      int stall;
      int taken;
      bit eager;
      bit held;
      taken = 0;
      eager = 0;
      held  = 0;
      forever begin
         if (taken % 32 == 0) begin
            eager = ($urandom_range(0, 2) == 0);
         end
         stall = eager ? 0 : $urandom_range(0, 3);
         if (!held && taken == HOLD_AT) begin
            stall = HOLD_CYCLES;
            held  = 1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   task automatic offer(input plan_row_type row);
      int gap;
      if (offers_made % 32 == 0) begin
         sender_eager = ($urandom_range(0, 2) == 0);
      end
      gap = sender_eager ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= row.rq;
      req_tuser   <= row.op;
      offer_typed <= row.has_known;
      offer_known <= row.known;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      offers_made++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_site(input logic site);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= site;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   function automatic plan_row_type row_access(input logic op, input logic [31:0] shape,
                                               input logic present, input logic fvalid,
                                               input logic [31:0] fshape,
                                               input logic [15:0] fslot);
      plan_row_type row;
      row = '0;
      row.op                  = op;
      row.rq.shape_id         = shape;
      row.rq.shape_present    = present;
      row.rq.fill_valid       = fvalid;
      row.rq.fill_shape_id    = fshape;
      row.rq.fill_slot        = fslot;
      return row;
   endfunction

   function automatic plan_row_type row_site(input logic site);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.site   = site;
      return row;
   endfunction

   function automatic plan_row_type typed(input plan_row_type row, input logic hit,
                                          input logic sv, input logic [15:0] slot,
                                          input logic [1:0] mode, input logic [2:0] used,
                                          input logic [31:0] hits, input logic [31:0] misses);
      row.has_known          = 1'b1;
      row.known              = '0;
      row.known.hit          = hit;
      row.known.slot_valid   = sv;
      row.known.slot         = slot;
      row.known.cache_mode   = mode;
      row.known.entries_used = used;
      row.known.hit_total    = hits;
      row.known.miss_total   = misses;
      return row;
   endfunction

   function automatic logic [31:0] pick_shape();
      return ($urandom_range(0, 9) < 8) ? shape_pool[$urandom_range(0, 5)] : $urandom();
   endfunction

   initial begin : stimulus
      plan_row_type row;

      // load site after reset
      add_row(typed(row_access(OP_ACCESS, 32'h0, 1, 0, 32'h0, 16'h0),
                    0, 0, 16'h0, MODE_UNINIT, 0, 0, 1));
      add_row(typed(row_access(OP_ACCESS, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 16'hFFFF),
                    0, 0, 16'h0, MODE_UNINIT, 0, 0, 2));
      add_row(typed(row_access(OP_ACCESS, 32'hFFFF_FFFF, 1, 1, 32'h0, 16'hFFFF),
                    0, 1, 16'hFFFF, MODE_MONO, 1, 0, 3));
      add_row(typed(row_access(OP_ACCESS, 32'hFFFF_FFFF, 1, 0, 32'h0, 16'h0),
                    1, 1, 16'hFFFF, MODE_MONO, 1, 1, 3));
      add_row(typed(row_access(OP_ACCESS, 32'h0, 1, 1, 32'hFFFF_FFFF, 16'h0),
                    0, 1, 16'h0, MODE_POLY, 2, 1, 4));
      add_row(typed(row_access(OP_ACCESS, 32'h0, 1, 0, 32'h0, 16'h0),
                    1, 1, 16'h0, MODE_POLY, 2, 2, 4));
      add_row(row_access(OP_ACCESS, 32'h1234_5678, 1, 1, 32'h0, 16'h00AA));
      add_row(row_access(OP_ACCESS, 32'hA5A5_A5A5, 1, 1, 32'h0, 16'h5555));
      // table full, next new shape goes megamorphic
      add_row(row_access(OP_ACCESS, 32'h0F0F_0F0F, 1, 1, 32'h0, 16'h1234));
      add_row(row_access(OP_ACCESS, 32'hFFFF_FFFF, 1, 0, 32'h0, 16'h0));
      add_row(row_access(OP_ACCESS, 32'h1234_5678, 1, 1, 32'h0, 16'h00FF));
      add_row(row_access(OP_INVALIDATE, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 16'hFFFF));
      add_row(row_access(OP_ACCESS, 32'h5A5A_5A5A, 0, 1, 32'h5A5A_5A5A, 16'h0007));
      // store site
      add_row(row_site(1'b0));
      add_row(row_access(OP_ACCESS, 32'h0, 0, 1, 32'hDEAD_BEEF, 16'h0007));
      add_row(row_access(OP_ACCESS, 32'hDEAD_BEEF, 1, 0, 32'h0, 16'h0));
      add_row(row_access(OP_ACCESS, 32'h1, 1, 1, 32'hDEAD_BEEF, 16'h0009));
      add_row(row_access(OP_ACCESS, 32'h2, 1, 1, 32'h2, 16'h0003));
      add_row(row_access(OP_ACCESS, 32'h3, 1, 1, 32'hDEAD_BEEF, 16'h0004));
      add_row(row_access(OP_ACCESS, 32'h2, 1, 0, 32'h0, 16'h0));
      add_row(row_access(OP_ACCESS, 32'h4, 1, 0, 32'h4, 16'hFFFF));
      add_row(row_access(OP_INVALIDATE, 32'h0, 0, 0, 32'h0, 16'h0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            write_site(plan[i].site);
         end else begin
            offer(plan[i]);
         end
      end

      for (int phase = 0; phase < 5; phase++) begin
         write_site((phase % 2 == 0) ? 1'b1 : 1'b0);
         foreach (shape_pool[i]) begin
            shape_pool[i] = $urandom();
         end
         if (phase == 1) begin
            shape_pool[0] = 32'h0;
            shape_pool[1] = 32'hFFFF_FFFF;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            row = '0;
            row.op                  = ($urandom_range(0, 39) == 0) ? OP_INVALIDATE : OP_ACCESS;
            row.rq.shape_id         = pick_shape();
            row.rq.shape_present    = ($urandom_range(0, 9) != 0);
            row.rq.fill_valid       = ($urandom_range(0, 3) != 0);
            row.rq.fill_shape_id    = pick_shape();
            row.rq.fill_slot        = 16'($urandom());
            offer(row);
         end
      end

      drain();
      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
